### rtl/sre_pkg.sv
// ============================================================================
// Sine reference package
// Shared types, register indexes and reset values of the sine reference core.
// ============================================================================
package sre_pkg;

    // Field widths fixed by the interface definition.
    localparam int AMP_W      = 15;
    localparam int MAG_W      = 15;
    localparam int REF_W      = 16;
    localparam int CNT_W      = 16;
    localparam int INC_W      = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_INDEX_W = 4;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_INCREMENT   = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_TICKS        = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FULL_AMPLITUDE    = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_REDUCED_AMPLITUDE = 4'd3;

    // Reset values: 60 Hz at a 20 kHz tick rate, step after 1417 ticks.
    localparam logic [INC_W-1:0] RST_PHASE_INCREMENT   = 32'd12884902;
    localparam logic [CNT_W-1:0] RST_STEP_TICKS        = 16'd1417;
    localparam logic [AMP_W-1:0] RST_FULL_AMPLITUDE    = 15'd13165;
    localparam logic [AMP_W-1:0] RST_REDUCED_AMPLITUDE = 15'd6583;

    // Input item: one control-period tick.
    typedef struct packed {
        logic tick;
    } tick_item_t;

    // Result item: scaled sine and amplitude selection flag.
    typedef struct packed {
        logic signed [REF_W-1:0] reference;
        logic                    stepped;
    } ref_item_t;

    // Side information travelling alongside the sine table read.
    typedef struct packed {
        logic             neg;
        logic             stepped;
        logic [AMP_W-1:0] amp;
    } lookup_t;

endpackage

### rtl/sre_stream_if.sv
// ============================================================================
// Streaming channel
// Valid/ready channel carrying one payload item per transfer.
// ============================================================================
interface sre_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

### rtl/sre_nco_ctrl.sv
// ============================================================================
// Oscillator control
// Configuration registers, phase accumulator, elapsed-tick counter and the
// quarter-wave address fold for the sine table.
// ============================================================================
module sre_nco_ctrl
    import sre_pkg::*;
#(
    parameter int SINE_TABLE_BITS = 10,
    parameter int PHASE_BITS      = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_INDEX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic                         advance,
    output logic [SINE_TABLE_BITS-2:0]   rom_addr,
    output lookup_t                      lookup
);

    localparam int QW = SINE_TABLE_BITS - 2;
    localparam logic [QW:0] QUARTER = {1'b1, {QW{1'b0}}};

    logic [PHASE_BITS-1:0]      phase_increment_reg;
    logic [CNT_W-1:0]           step_ticks_reg;
    logic [AMP_W-1:0]           full_amplitude_reg;
    logic [AMP_W-1:0]           reduced_amplitude_reg;
    logic [PHASE_BITS-1:0]      phase_reg;
    logic [PHASE_BITS-1:0]      phase_next;
    logic [CNT_W-1:0]           elapsed_reg;
    logic [CNT_W-1:0]           elapsed_next;
    logic [SINE_TABLE_BITS-1:0] table_index;
    logic [QW:0]                offset;
    logic                       stepped;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_increment_reg   <= RST_PHASE_INCREMENT[PHASE_BITS-1:0];
            step_ticks_reg        <= RST_STEP_TICKS;
            full_amplitude_reg    <= RST_FULL_AMPLITUDE;
            reduced_amplitude_reg <= RST_REDUCED_AMPLITUDE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PHASE_INCREMENT:   phase_increment_reg   <= cfg_data[PHASE_BITS-1:0];
                CFG_STEP_TICKS:        step_ticks_reg        <= cfg_data[CNT_W-1:0];
                CFG_FULL_AMPLITUDE:    full_amplitude_reg    <= cfg_data[AMP_W-1:0];
                CFG_REDUCED_AMPLITUDE: reduced_amplitude_reg <= cfg_data[AMP_W-1:0];
                default:               ;
            endcase
        end
    end

    // The counter stops once it reaches the step time.
    assign stepped = (elapsed_reg >= step_ticks_reg);

    always_comb
    begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        if (advance)
        begin
            phase_next = phase_reg + phase_increment_reg;
            if (!stepped)
            begin
                elapsed_next = elapsed_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            elapsed_reg <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
        end
    end

    // Fold the table index onto the first quarter wave; the top bit gives the sign.
    assign table_index = phase_reg[PHASE_BITS-1 -: SINE_TABLE_BITS];
    assign offset      = {1'b0, table_index[QW-1:0]};
    assign rom_addr    = table_index[QW] ? (QUARTER - offset) : offset;

    // Amplitude selection for the current tick.
    always_comb
    begin
        lookup.neg     = table_index[SINE_TABLE_BITS-1];
        lookup.stepped = stepped;
        lookup.amp     = stepped ? reduced_amplitude_reg : full_amplitude_reg;
    end

endmodule

### rtl/sre_sine_rom.sv
// ============================================================================
// Quarter-wave sine table
// Magnitude of sin over one quarter wave in Q1.15, built at elaboration from
// an odd polynomial, with a registered read port.
// ============================================================================
module sre_sine_rom
    import sre_pkg::*;
#(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [SINE_TABLE_BITS-2:0] addr,
    output logic [MAG_W-1:0]           rd_data_reg
);

    localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
    localparam int U_SHIFT = 30 - (SINE_TABLE_BITS - 2);

    // Q30 coefficients of sin(pi/2 * u).
    localparam logic [63:0] C1 = 64'd1686629713;
    localparam logic [63:0] C3 = 64'd693598671;
    localparam logic [63:0] C5 = 64'd85569306;
    localparam logic [63:0] C7 = 64'd5026995;
    localparam logic [63:0] C9 = 64'd172272;

    typedef logic [MAG_W-1:0] rom_t [QUARTER+1];

    // Polynomial evaluation in Horner form, rounded to Q1.15 and clamped.
    function automatic logic [MAG_W-1:0] quarter_sine(input int k);
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] p;
        logic [63:0] s;
        u  = 64'(k) << U_SHIFT;
        u2 = (u * u) >> 30;
        p  = C9;
        p  = C7 - ((p * u2) >> 30);
        p  = C5 - ((p * u2) >> 30);
        p  = C3 - ((p * u2) >> 30);
        p  = C1 - ((p * u2) >> 30);
        s  = (u * p) >> 30;
        s  = (s + (64'd1 << 14)) >> 15;
        if (s > 64'd32767)
        begin
            s = 64'd32767;
        end
        return s[MAG_W-1:0];
    endfunction

    function automatic rom_t build_rom();
        rom_t r;
        for (int k = 0; k <= QUARTER; k++)
        begin
            r[k] = quarter_sine(k);
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // Registered read, held while the pipeline stalls.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_data_reg <= SINE_ROM[addr];
        end
    end

endmodule

### rtl/sre_scale.sv
// ============================================================================
// Amplitude scaling
// Multiplies the sine magnitude by the selected amplitude, rounds half away
// from zero, restores the sign and holds the result item.
// ============================================================================
module sre_scale
    import sre_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [MAG_W-1:0] mag,
    input  lookup_t          lookup,
    output ref_item_t        result_reg
);

    localparam int PROD_W = AMP_W + MAG_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (MAG_W - 1);

    logic [PROD_W-1:0] product;
    logic [SUM_W-1:0]  rounded;
    logic [REF_W-1:0]  magnitude;
    ref_item_t         result_next;

    // Unsigned product, then the Q1.15 scale is dropped with rounding.
    assign product   = lookup.amp * mag;
    assign rounded   = {1'b0, product} + ROUND_HALF;
    assign magnitude = rounded[MAG_W +: REF_W];

    always_comb
    begin
        result_next.reference = lookup.neg ? (REF_W'(0) - magnitude) : magnitude;
        result_next.stepped   = lookup.stepped;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

endmodule

### rtl/sine_reference_with_amplitude_step_core.sv
// ============================================================================
// Sine reference with amplitude step
// Each accepted tick passes the table read stage, then the scaling stage
// into the result register. Throughput: one tick per cycle unless the
// results are back-pressured; the registered sine table read sets the
// pipeline depth. Reset clears the phase, the tick counter, the pipeline
// valid flags and restores the configuration registers.
// ============================================================================
module sine_reference_with_amplitude_step_core
    import sre_pkg::*;
#(
    parameter int SINE_TABLE_BITS = 10,
    parameter int PHASE_BITS      = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    sre_stream_if.sink             ticks,
    sre_stream_if.source           results
);

    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       out_adv;
    logic                       s1_adv;
    logic                       in_fire;
    logic [SINE_TABLE_BITS-2:0] rom_addr;
    lookup_t                    lookup;
    lookup_t                    lookup_reg;
    logic [MAG_W-1:0]           mag;
    ref_item_t                  result;

    // Each stage moves on when the stage after it is free or being emptied.
    assign out_adv     = !out_valid_reg || results.ready;
    assign s1_adv      = !s1_valid_reg || out_adv;
    assign in_fire     = ticks.valid && s1_adv;
    assign ticks.ready = s1_adv;

    // Phase, counter and table address for the accepted tick.
    sre_nco_ctrl #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .PHASE_BITS      (PHASE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (in_fire && ticks.data.tick),
        .rom_addr  (rom_addr),
        .lookup    (lookup)
    );

    // Table read stage.
    sre_sine_rom #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_rom (
        .clk         (clk),
        .en          (s1_adv),
        .addr        (rom_addr),
        .rd_data_reg (mag)
    );

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            lookup_reg <= lookup;
        end
    end

    // Scaling stage into the result register.
    sre_scale u_scale (
        .clk        (clk),
        .en         (out_adv),
        .mag        (mag),
        .lookup     (lookup_reg),
        .result_reg (result)
    );

    // Valid flags of the two stages.
    assign s1_valid_next  = s1_adv ? in_fire : s1_valid_reg;
    assign out_valid_next = out_adv ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.data  = result;

endmodule

### rtl/sre_checker.sv
// ============================================================================
// Sine reference checker
// Port-level checks of the sine reference core, bound to the top level.
// ============================================================================
module sre_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] out_reference,
    input logic               out_stepped
);

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_reference)
                                    && $stable(out_stepped))
        else $error("stalled result changed or was dropped");

    // Ticks are refused only when the result register is full and stalled.
    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("tick refused while the pipeline had room");

    // A tick transfer reaches the output once the table read stage is done and the output can move.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready ##1 (!out_valid || out_ready) |=> out_valid)
        else $error("result missing two cycles after tick transfer");

    // The scaled sine never reaches full scale.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_reference >= -16'sd32766 && out_reference <= 16'sd32766)
        else $error("reference outside the scaled sine range");

endmodule

bind sine_reference_with_amplitude_step_core sre_checker u_sre_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (ticks.valid),
    .in_ready      (ticks.ready),
    .out_valid     (results.valid),
    .out_ready     (results.ready),
    .out_reference (results.data.reference),
    .out_stepped   (results.data.stepped)
);

### test/tb.sv
// ============================================================================
// Sine reference with amplitude step: testbench
// Drives control ticks through the valid/ready channel and writes the four
// configuration registers between phases of traffic. A scoreboard keeps its
// own phase accumulator, tick counter and sine table. From these it works out
// each expected reference sample and its step flag, and compares them with
// what the core returns.
// ============================================================================
module tb;
    import sre_pkg::*;

    localparam int TABLE_BITS  = 10;
    localparam int PHASE_W     = 32;
    localparam int TABLE_SIZE  = 1 << TABLE_BITS;
    localparam int QUARTER     = TABLE_SIZE / 4;
    localparam int LATENCY     = 2;
    localparam int HOLD_CYCLES = 80;
    localparam int MAX_SHOWN   = 40;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 50;
    localparam int LIMIT_TIME  = 2000000;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE    = 4'd15;
    localparam logic [PHASE_W-1:0]     QUARTER_TURN = 32'h4000_0000;
    localparam logic [AMP_W-1:0]       AMP_MAX      = '1;

    // Q30 coefficients of the odd polynomial for sin(pi/2 * u).
    localparam longint unsigned POLY_C1 = 64'd1686629713;
    localparam longint unsigned POLY_C3 = 64'd693598671;
    localparam longint unsigned POLY_C5 = 64'd85569306;
    localparam longint unsigned POLY_C7 = 64'd5026995;
    localparam longint unsigned POLY_C9 = 64'd172272;

    typedef struct {
        ref_item_t value;
        int        serial;
    } awaited_t;

    // Scoreboard: sine reference predictor and queue of awaited samples.
    class sine_scoreboard;
        logic [PHASE_W-1:0] increment;
        logic [CNT_W-1:0]   step_at;
        logic [AMP_W-1:0]   amp_full;
        logic [AMP_W-1:0]   amp_reduced;
        logic [PHASE_W-1:0] phase_acc;
        logic [CNT_W-1:0]   tick_count;
        int                 sine_rom [TABLE_SIZE];
        awaited_t           awaited [$];
        int                 errors;
        int                 accepted;
        int                 held;
        int                 checked;
        int                 reduced_seen;

        function new();
            for (int i = 0; i < TABLE_SIZE; i++) begin
                if (i < QUARTER)
                    sine_rom[i] = quarter_sine(i);
                else if (i < 2 * QUARTER)
                    sine_rom[i] = quarter_sine(2 * QUARTER - i);
                else if (i < 3 * QUARTER)
                    sine_rom[i] = -quarter_sine(i - 2 * QUARTER);
                else
                    sine_rom[i] = -quarter_sine(4 * QUARTER - i);
            end
            increment   = RST_PHASE_INCREMENT;
            step_at     = RST_STEP_TICKS;
            amp_full    = RST_FULL_AMPLITUDE;
            amp_reduced = RST_REDUCED_AMPLITUDE;
            phase_acc   = '0;
            tick_count  = '0;
        endfunction

        // Quarter-wave sine magnitude in Q1.15, evaluated by Horner's rule.
        function int quarter_sine(int unsigned k);
            longint unsigned u;
            longint unsigned u2;
            longint unsigned p;
            longint unsigned s;
            u  = 64'(k) << (30 - (TABLE_BITS - 2));
            u2 = (u * u) >> 30;
            p  = POLY_C9;
            p  = POLY_C7 - ((p * u2) >> 30);
            p  = POLY_C5 - ((p * u2) >> 30);
            p  = POLY_C3 - ((p * u2) >> 30);
            p  = POLY_C1 - ((p * u2) >> 30);
            s  = (u * p) >> 30;
            s  = (s + 64'd16384) >> 15;
            if (s > 64'd32767)
                s = 64'd32767;
            return int'(s);
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            case (index)
                CFG_PHASE_INCREMENT:   increment   = value[PHASE_W-1:0];
                CFG_STEP_TICKS:        step_at     = value[CNT_W-1:0];
                CFG_FULL_AMPLITUDE:    amp_full    = value[AMP_W-1:0];
                CFG_REDUCED_AMPLITUDE: amp_reduced = value[AMP_W-1:0];
                default: ;
            endcase
        endfunction

        // Work out the sample for the current state, then advance on a tick.
        function void note_tick(logic advance);
            awaited_t        next;
            int              s;
            int unsigned     mag;
            logic [AMP_W-1:0] amp;
            longint unsigned scaled;
            logic [REF_W-1:0] r;
            s = sine_rom[phase_acc[PHASE_W-1 -: TABLE_BITS]];
            next.value.stepped = (tick_count >= step_at);
            amp    = next.value.stepped ? amp_reduced : amp_full;
            mag    = (s < 0) ? -s : s;
            scaled = (64'(amp) * 64'(mag) + 64'd16384) >> 15;
            r      = scaled[REF_W-1:0];
            next.value.reference = (s < 0) ? -r : r;
            next.serial = accepted;
            awaited.push_back(next);
            accepted++;
            if (advance) begin
                phase_acc = phase_acc + increment;
                if (tick_count < step_at)
                    tick_count = tick_count + 1'b1;
            end
            else begin
                held++;
            end
        endfunction

        task report(string what);
            errors++;
            if (errors <= MAX_SHOWN)
                $display("mismatch: %s", what);
        endtask

        task check_result(ref_item_t got);
            awaited_t want;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected sample reference=%0d stepped=%0b",
                                 got.reference, got.stepped));
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (want.value.stepped)
                reduced_seen++;
            if (got.reference !== want.value.reference)
                report($sformatf("tick %0d reference %0d, expected %0d",
                                 want.serial, got.reference, want.value.reference));
            if (got.stepped !== want.value.stepped)
                report($sformatf("tick %0d stepped %0b, expected %0b",
                                 want.serial, got.stepped, want.value.stepped));
        endtask

        function int pending();
            return awaited.size();
        endfunction

        task close();
            if (awaited.size() != 0)
                report($sformatf("%0d samples never arrived", awaited.size()));
        endtask
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    sre_stream_if #(.payload_t(tick_item_t)) ticks_if ();
    sre_stream_if #(.payload_t(ref_item_t))  results_if ();

    sine_scoreboard sb;
    bit             sender_steady   = 1'b0;
    bit             receiver_steady = 1'b0;
    bit             hold_request    = 1'b0;
    int             holds_done      = 0;
    int             settings_applied = 0;

    sine_reference_with_amplitude_step_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ticks     (ticks_if),
        .results   (results_if)
    );

    always #5 clk = ~clk;

    // Watch both channels: note each tick transfer, check each sample transfer.
    always @(posedge clk) begin
        if (rst_n) begin
            if (ticks_if.valid && ticks_if.ready)
                sb.note_tick(ticks_if.data.tick);
            if (results_if.valid && results_if.ready)
                sb.check_result(results_if.data);
        end
    end

    // Receiver: random back-pressure, or a long hold-off when one is requested.
    initial begin
        results_if.ready <= 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever begin
            if (hold_request) begin
                results_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                holds_done++;
            end
            else begin
                results_if.ready <= receiver_steady || ($urandom_range(99, 0) >= 25);
                @(posedge clk);
            end
        end
    end

    // Overall time limit.
    initial begin
        #(LIMIT_TIME);
        $display("== FAIL ==");
        $finish;
    end

    // Offer one tick, with an occasional gap first, and wait for its transfer.
    task send_tick(input logic advance, input bit may_idle);
        tick_item_t item;
        item.tick = advance;
        if (may_idle && $urandom_range(99, 0) < 25) begin
            ticks_if.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        ticks_if.valid <= 1'b1;
        ticks_if.data  <= item;
        @(posedge clk);
        while (!ticks_if.ready)
            @(posedge clk);
    endtask

    // Stop offering ticks until every awaited sample has come back.
    // The first edge lets the monitor note the last tick transfer.
    task pause_for_results();
        ticks_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (LATENCY + 1) @(posedge clk);
    endtask

    task put_reg(input logic [CFG_INDEX_W-1:0] index, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        sb.write_reg(index, value);
    endtask

    // Write all registers; bits above each register's width carry noise.
    task apply_settings(input logic [PHASE_W-1:0] inc, input logic [CNT_W-1:0] step,
                        input logic [AMP_W-1:0] full, input logic [AMP_W-1:0] reduced);
        logic [31:0] noise;
        noise = $urandom();
        put_reg(CFG_PHASE_INCREMENT, inc);
        put_reg(CFG_STEP_TICKS, {noise[31:16], step});
        put_reg(CFG_FULL_AMPLITUDE, {noise[31:15], full});
        noise = $urandom();
        put_reg(CFG_REDUCED_AMPLITUDE, {noise[31:15], reduced});
        put_reg(CFG_SPARE, $urandom());
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    function logic [AMP_W-1:0] pick_amp();
        case ($urandom_range(3, 0))
            0:       return '0;
            1:       return AMP_MAX;
            default: return AMP_W'($urandom());
        endcase
    endfunction

    initial begin
        logic [PHASE_W-1:0] inc;
        logic [CNT_W-1:0]   step;
        logic [31:0]        sum;

        sb = new();
        ticks_if.valid <= 1'b0;
        ticks_if.data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration, including a held tick.
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b0);
        pause_for_results();

        // Bring the phase back to zero, then walk the four quarter points
        // at full scale and cross the step into a zero reduced amplitude.
        apply_settings(32'd0 - sb.phase_acc, 16'd3, AMP_MAX, '0);
        send_tick(1'b1, 1'b0);
        pause_for_results();
        apply_settings(QUARTER_TURN, 16'd7, AMP_MAX, '0);
        repeat (4) send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        pause_for_results();

        // Largest increment steps backwards; step at zero selects reduced.
        apply_settings('1, '0, '0, AMP_MAX);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b0);
        pause_for_results();

        // Zero increment holds the phase; a raised step lets the counter resume.
        apply_settings('0, '1, AMP_MAX, AMP_MAX);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b0);

        // Random phases, each under fresh settings.
        for (int phase_no = 0; phase_no < PHASES; phase_no++) begin
            pause_for_results();
            case ($urandom_range(4, 0))
                0:       inc = $urandom();
                1:       inc = $urandom_range(32'h00FF_FFFF, 0);
                2:       inc = '0;
                3:       inc = '1;
                default: inc = QUARTER_TURN;
            endcase
            case ($urandom_range(3, 0))
                0:       step = '0;
                1:       step = '1;
                2:       step = CNT_W'($urandom());
                default: begin
                    sum  = 32'(sb.tick_count) + $urandom_range(40, 0);
                    step = (sum > 32'hFFFF) ? '1 : sum[CNT_W-1:0];
                end
            endcase
            apply_settings(inc, step, pick_amp(), pick_amp());
            sender_steady   = (phase_no == 3) || (phase_no == 6);
            receiver_steady = (phase_no == 3);
            if (phase_no == 6)
                hold_request = 1'b1;
            repeat (PHASE_ITEMS)
                send_tick($urandom_range(99, 0) < 85, !sender_steady);
        end

        pause_for_results();
        sb.close();
        $display("Covered %0d ticks (%0d held) over %0d register settings.",
                 sb.accepted, sb.held, settings_applied);
        $display("Checked %0d samples, %0d at reduced amplitude; %0d receiver hold-offs.",
                 sb.checked, sb.reduced_seen, holds_done);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
